// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the odometry integrator RTL.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/wop_pkg.sv =====
// Shared types, constants and tables of the wheel odometry pose integrator.
// No dependencies.
`default_nettype none
package wop_pkg;

    localparam int COUNTER_BITS       = 32;
    localparam int CORDIC_STEPS_DEF   = 24;
    localparam int POSITION_FRAC_BITS = 16;
    localparam int WORK_FRAC          = POSITION_FRAC_BITS + 6;
    // |S|*mpt/4 in Q30, then down to Q(WORK_FRAC): one combined floor shift
    localparam int DIST_SHIFT         = 34 - WORK_FRAC;
    localparam int DELTA_W            = (COUNTER_BITS < 33) ? COUNTER_BITS : 33;
    localparam int SUM_W              = DELTA_W + 2;
    localparam int CW                 = 60;   // CORDIC vector width
    localparam int POS_W              = 48;
    localparam int CFG_W              = 40;
    localparam int CFG_IDX_W          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APD = 2'd1;

    localparam logic [31:0] MPT_RESET = 32'd7906077;
    localparam logic [39:0] APD_RESET = 40'd322122547;
    localparam logic [31:0] INV_GAIN  = 32'd2608131496;

    typedef struct packed {
        logic        [31:0] sample_time;
        logic signed [31:0] front_left_count;
        logic signed [31:0] front_right_count;
        logic signed [31:0] back_left_count;
        logic signed [31:0] back_right_count;
    } t_in_item;

    typedef struct packed {
        logic        [31:0] result_time;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic        [31:0] heading_angle;
    } t_out_item;

    // multiply steps: A = distance scale, B = inverse gain, H = heading
    typedef enum logic [2:0] {
        MOP_A0, MOP_A1, MOP_H0, MOP_B0, MOP_H1, MOP_B1, MOP_H2
    } t_mop;

    typedef struct packed {
        logic       load;
        logic       sum;
        logic       mul_go;
        t_mop       mul_op;
        logic       acc_go;
        t_mop       acc_op;
        logic       fold;
        logic       rot;
        logic [4:0] rot_idx;
        logic       commit;
    } t_cmd;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wop_datapath.sv =====
// Datapath: count deltas, shared 32x32 multiplier, iterative CORDIC, pose accumulators.
// Depends on wop_pkg; driven by wop_ctrl commands.
`default_nettype none
module wop_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wop_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wop_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire wop_pkg::t_in_item             i_item,
    input  wire wop_pkg::t_cmd                 i_cmd,
    output wop_pkg::t_out_item                 o_item
);
    import wop_pkg::*;

    function automatic logic signed [DELTA_W-1:0] wheel_delta(input logic [31:0] cur,
                                                               input logic [31:0] prv);
        logic signed [32:0] d;
        d = signed'({cur[31], cur}) - signed'({prv[31], prv});
        return d[DELTA_W-1:0];
    endfunction

    logic [31:0] r_mpt;
    logic [39:0] r_apd;
    logic [31:0] r_prev [4];
    logic [31:0] r_time, r_out_time;
    logic signed [DELTA_W-1:0] r_dfl, r_dfr, r_dbl, r_dbr;
    logic [SUM_W-1:0] r_mag;
    logic             r_sgn;
    logic [41:0]      r_diff;
    logic [63:0]      r_prod;
    logic [67:0]      r_acc_d;
    logic [87:0]      r_acc_b;
    logic [41:0]      r_acc_h;
    logic signed [CW-1:0] r_x, r_y;
    logic [31:0]      r_ang;
    logic [POS_W-1:0] r_xacc, r_yacc;
    logic [31:0]      r_heading;

    logic signed [SUM_W-1:0] c_s, c_diff;
    logic [63:0] w_mag64, w_d64;
    logic [31:0] c_a, c_b;
    logic [31:0] c_ang, c_ang_q;
    logic        c_flip;
    logic signed [CW-1:0] c_mag3, c_xs, c_ys;
    logic [31:0] c_atan;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt <= MPT_RESET;
            r_apd <= APD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MPT) r_mpt <= i_cfg_data[31:0];
            if (i_cfg_idx == CFG_APD) r_apd <= i_cfg_data;
        end
    end

    always_comb begin
        c_s = SUM_W'(r_dfl) + SUM_W'(r_dfr) + SUM_W'(r_dbl) + SUM_W'(r_dbr);
        c_diff = (SUM_W'(r_dfr) + SUM_W'(r_dbr)) - (SUM_W'(r_dfl) + SUM_W'(r_dbl));
        w_mag64 = 64'(r_mag);
        w_d64 = 64'(r_acc_d >> DIST_SHIFT);
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            MOP_A0:  begin c_a = w_mag64[31:0];  c_b = r_mpt;         end
            MOP_A1:  begin c_a = w_mag64[63:32]; c_b = r_mpt;         end
            MOP_H0:  begin c_a = r_diff[31:0];   c_b = r_apd[31:0];   end
            MOP_B0:  begin c_a = w_d64[31:0];    c_b = INV_GAIN;      end
            MOP_H1:  begin c_a = r_diff[31:0];   c_b = 32'(r_apd[39:32]); end
            MOP_B1:  begin c_a = w_d64[63:32];   c_b = INV_GAIN;      end
            default: begin c_a = 32'(r_diff[41:32]); c_b = r_apd[31:0]; end
        endcase
    end

    always_comb begin
        c_ang   = r_heading + r_acc_h[41:10];
        c_ang_q = c_ang + 32'h4000_0000;
        c_flip  = c_ang_q[31];
        c_mag3  = CW'(r_acc_b[87:32]);
        c_xs    = r_x >>> i_cmd.rot_idx;
        c_ys    = r_y >>> i_cmd.rot_idx;
        c_atan  = atan_entry(i_cmd.rot_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time   <= i_item.sample_time;
            r_dfl    <= wheel_delta(i_item.front_left_count, r_prev[0]);
            r_dfr    <= wheel_delta(i_item.front_right_count, r_prev[1]);
            r_dbl    <= wheel_delta(i_item.back_left_count, r_prev[2]);
            r_dbr    <= wheel_delta(i_item.back_right_count, r_prev[3]);
            r_prev[0] <= i_item.front_left_count;
            r_prev[1] <= i_item.front_right_count;
            r_prev[2] <= i_item.back_left_count;
            r_prev[3] <= i_item.back_right_count;
        end
        if (i_cmd.sum) begin
            r_sgn  <= c_s[SUM_W-1];
            r_mag  <= c_s[SUM_W-1] ? SUM_W'(-c_s) : SUM_W'(c_s);
            r_diff <= 42'(c_diff);
        end
        if (i_cmd.mul_go) begin
            r_prod <= 64'(c_a) * 64'(c_b);
        end
        if (i_cmd.acc_go) begin
            case (i_cmd.acc_op)
                MOP_A0: r_acc_d <= 68'(r_prod);
                MOP_A1: r_acc_d <= r_acc_d + (68'(r_prod) << 32);
                MOP_H0: r_acc_h <= r_prod[41:0];
                MOP_B0: r_acc_b <= 88'(r_prod);
                MOP_B1: r_acc_b <= r_acc_b + (88'(r_prod) << 32);
                default: r_acc_h <= r_acc_h + {r_prod[9:0], 32'd0};
            endcase
        end
        if (i_cmd.fold) begin
            // left half-plane: turn angle by half a turn and negate vector
            r_ang <= {c_ang[31] ^ c_flip, c_ang[30:0]};
            r_x   <= (r_sgn ^ c_flip) ? -c_mag3 : c_mag3;
            r_y   <= '0;
        end
        if (i_cmd.rot) begin
            if (!r_ang[31]) begin
                r_x   <= r_x - c_ys;
                r_y   <= r_y + c_xs;
                r_ang <= r_ang - c_atan;
            end else begin
                r_x   <= r_x + c_ys;
                r_y   <= r_y - c_xs;
                r_ang <= r_ang + c_atan;
            end
        end
        if (i_cmd.commit) begin
            r_out_time <= r_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xacc    <= '0;
            r_yacc    <= '0;
            r_heading <= '0;
        end else if (i_cmd.commit) begin
            r_xacc    <= r_xacc + r_x[6 +: POS_W];
            r_yacc    <= r_yacc + r_y[6 +: POS_W];
            r_heading <= r_heading + r_acc_h[40:9];
        end
    end

    assign o_item.result_time   = r_out_time;
    assign o_item.pos_x         = r_xacc;
    assign o_item.pos_y         = r_yacc;
    assign o_item.heading_angle = r_heading;

endmodule
`default_nettype wire

// ===== rtl/core/wop_ctrl.sv =====
// Controller: sequences accept, sum, multiply steps, fold, CORDIC steps and commit.
// Depends on wop_pkg; drives wop_datapath.
`default_nettype none
module wop_ctrl #(
    parameter int CORDIC_STEPS = wop_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output wop_pkg::t_cmd o_cmd
);
    import wop_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] LAST_MUL  = 5'd7;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SUM    = 6'b000010,
        S_MUL    = 6'b000100,
        S_FOLD   = 6'b001000,
        S_ROT    = 6'b010000,
        S_COMMIT = 6'b100000
    } t_state;

    function automatic t_mop mop_at(input logic [4:0] k);
        t_mop m;
        case (k)
            5'd0:    m = MOP_A0;
            5'd1:    m = MOP_A1;
            5'd2:    m = MOP_H0;
            5'd3:    m = MOP_B0;
            5'd4:    m = MOP_H1;
            5'd5:    m = MOP_B1;
            default: m = MOP_H2;
        endcase
        return m;
    endfunction

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic r_have_prev, n_have_prev;
    logic r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_have_prev = r_have_prev;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.mul_op  = mop_at(r_cnt);
        o_cmd.acc_op  = mop_at(r_cnt - 5'd1);
        o_cmd.rot_idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load  = 1'b1;
                    n_have_prev = 1'b1;
                    // first item only primes the stored counts
                    if (r_have_prev) n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_go = (r_cnt != LAST_MUL);
                o_cmd.acc_go = (r_cnt != 5'd0);
                n_cnt        = r_cnt + 5'd1;
                if (r_cnt == LAST_MUL) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_cnt      = '0;
                n_state    = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/core/wheel_odometry_pose_integrator_unit.sv =====
// Top level of the wheel odometry pose integrator: controller plus datapath.
// Depends on wop_pkg, wop_ctrl, wop_datapath and assert_macros.svh.
`default_nettype none
// Integrates a differential-drive pose from four cumulative encoder counts per item.
// The first item after reset only primes the stored counts and gives no result.
// Each later item passes an accept step, a sum step, the multiply steps on the
// shared 32x32 multiplier, a fold step, CORDIC_STEPS iterative CORDIC rotation
// steps and a commit step, which waits while the previous result is unread.
// A finished result waits in the output register while the next item is
// accepted. Configuration written while idle takes effect on the next item;
// pose outputs are Q32.16 metres, heading a 32-bit binary angle.
module wheel_odometry_pose_integrator_unit #(
    parameter int CORDIC_STEPS = wop_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wop_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wop_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire wop_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output wop_pkg::t_out_item                 o_out_item
);
    import wop_pkg::*;

    t_cmd w_cmd;

    wop_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    wop_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (w_cmd),
        .o_item     (o_out_item)
    );

`include "assert_macros.svh"
    `ASSERT_ALWAYS(a_busy_not_ready, i_clk, i_rst_n, !(o_in_ready && (w_cmd.mul_go || w_cmd.rot)))
    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n, !(w_cmd.commit && o_out_valid && !i_out_ready))
    `ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_cmd.commit, o_out_valid)

endmodule
`default_nettype wire
